// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/rwav_pkg.sv -----
// Types and constants of the WAV stream parser.
package rwav_pkg;
    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] REQ_RATE = 32'd48000;
    localparam logic [15:0] REQ_BITS = 16'd16;
    localparam logic [31:0] RIFF_HDR_BYTES = 32'd12;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_NOT_WAVE   = 4'd0;
    localparam logic [3:0] ERR_FMT_SMALL  = 4'd1;
    localparam logic [3:0] ERR_NO_FMT     = 4'd2;
    localparam logic [3:0] ERR_FORMAT     = 4'd3;
    localparam logic [3:0] ERR_CHANNELS   = 4'd4;
    localparam logic [3:0] ERR_RATE       = 4'd5;
    localparam logic [3:0] ERR_BEYOND     = 4'd6;
    localparam logic [3:0] ERR_NOT_FRAME  = 4'd7;
    localparam logic [3:0] ERR_FILE_SMALL = 4'd8;
    localparam logic [3:0] ERR_NO_DATA    = 4'd9;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_WAVE   = 6'b000010,
        PH_FMT    = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_TRAIL  = 6'b100000
    } phase_t;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  error_code;
        logic        channel;
        logic [29:0] frame_index;
        logic [15:0] sample_value;
        logic        last;
    } result_t;

    // Up to two results caused by one byte.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } rpair_t;
endpackage

// ----- rtl/riff_wav_pcm_stream_parser_top.sv -----
// WAV RIFF parser: one file byte per s_ word, samples and status per m_ word.
// Write the file's byte length on the cfg channel before streaming a file
// (cfg_ready is always high). Each accepted byte is classified in the cycle it
// arrives and may cause up to two result words (a sample, then a done
// report). m_tuser tells the kind of each word and m_tlast marks the last word
// that a byte causes.
// Results pass through a four-entry queue of result pairs; a pair is written
// as its byte is accepted and shown on m_ from the queue head. Throughput is
// one byte per cycle while the queue is not full; a pair of two results keeps
// its entry until both are taken. s_tready drops only while the queue is
// full, so a stalled receiver back-pressures the byte stream once it fills.
// Errors halt the parser until aresetn (synchronous, clears all parse state).
module riff_wav_pcm_stream_parser_top import rwav_pkg::*; #(
    parameter int QDEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] error_code, [4] channel,
                                   // [34:5] frame_index, [50:35] sample_value
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    logic [31:0] total_len_reg;
    logic        q_push, q_full, q_pop, q_empty;
    rpair_t      q_in, q_out;
    result_t     w;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) total_len_reg <= '0;
        else if (cfg_valid) total_len_reg <= cfg_data;
    end

    rwav_front u_front (
        .aclk, .aresetn, .total_len(total_len_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .q_push, .q_data(q_in), .q_full
    );

    rwav_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    rwav_back u_back (
        .aclk, .aresetn, .q_data(q_out), .q_empty, .q_pop,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_word(w)
    );

    assign m_tdata = {5'b00000, w.sample_value, w.frame_index, w.channel, w.error_code};
    assign m_tuser = w.kind;
    assign m_tlast = w.last;
endmodule

// ----- rtl/rwav_front.sv -----
// Front end: accepts bytes, walks the chunk structure and forms result pairs.
module rwav_front import rwav_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] total_len,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        q_push,
    output rpair_t      q_data,
    input  logic        q_full
);
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  shift_reg, shift_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  low_reg, low_next;
    logic        chan_reg, chan_next;
    logic [29:0] frame_reg, frame_next;
    logic        seen_reg, seen_next;
    logic        halt_reg, halt_next;
    logic [3:0]  fidx_reg, fidx_next;

    logic        acc;
    logic [32:0] after, left;
    result_t     res [2];
    logic [1:0]  cnt;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;
    assign after = {1'b0, pos_reg} + 33'd1;
    assign left = ({1'b0, total_len} > after) ? {1'b0, total_len} - after : 33'd0;

    always_comb begin
        logic halt_now;
        logic [3:0] ecode;
        phase_next = phase_reg; pos_next = pos_reg; shift_next = shift_reg;
        tag_next = tag_reg; rem_next = rem_reg; fmt_next = fmt_reg;
        chans_next = chans_reg; rate_next = rate_reg; bits_next = bits_reg;
        low_next = low_reg; chan_next = chan_reg; frame_next = frame_reg;
        seen_next = seen_reg; halt_next = halt_reg; fidx_next = fidx_reg;
        res[0] = '0; res[1] = '0; cnt = 2'd0;
        halt_now = 1'b0; ecode = ERR_NOT_WAVE;
        if (acc && !halt_reg) begin
            if (pos_reg == 32'd0 && total_len < RIFF_HDR_BYTES) begin
                res[0].kind = KIND_ERROR; res[0].error_code = ERR_FILE_SMALL;
                cnt = 2'd1; halt_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (shift_reg == 3'd0 &&
                            ({1'b0, pos_reg} + 33'd8) > {1'b0, total_len}) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            if (!shift_reg[2])
                                tag_next[shift_reg[1:0]*8 +: 8] = in_byte;
                            else
                                rem_next[shift_reg[1:0]*8 +: 8] = in_byte;
                            shift_next = shift_reg + 3'd1;
                            if (shift_reg == 3'd7) begin
                                // Full header in hand: dispatch on the tag.
                                if (tag_next == TAG_RIFF) begin
                                    tag_next = '0; phase_next = PH_WAVE;
                                end else if (tag_next == TAG_FMT) begin
                                    if (rem_next < 32'd16) begin
                                        halt_now = 1'b1; ecode = ERR_FMT_SMALL;
                                    end else begin
                                        rem_next = rem_next - 32'd16;
                                        fidx_next = '0; phase_next = PH_FMT;
                                    end
                                end else if (tag_next == TAG_DATA) begin
                                    priority if (chans_reg == 16'd0) begin
                                        halt_now = 1'b1; ecode = ERR_NO_FMT;
                                    end else if (fmt_reg != 16'd1 || bits_reg != REQ_BITS) begin
                                        halt_now = 1'b1; ecode = ERR_FORMAT;
                                    end else if (chans_reg != 16'd2) begin
                                        halt_now = 1'b1; ecode = ERR_CHANNELS;
                                    end else if (rate_reg != REQ_RATE) begin
                                        halt_now = 1'b1; ecode = ERR_RATE;
                                    end else if ({1'b0, rem_next} > left) begin
                                        halt_now = 1'b1; ecode = ERR_BEYOND;
                                    end else if (rem_next[1:0] != 2'd0) begin
                                        halt_now = 1'b1; ecode = ERR_NOT_FRAME;
                                    end else begin
                                        frame_next = '0; chan_next = 1'b0;
                                        seen_next = 1'b0;
                                        phase_next = (rem_next != 0) ? PH_DATA : PH_HEADER;
                                    end
                                end else begin
                                    phase_next = (rem_next != 0) ? PH_SKIP : PH_HEADER;
                                end
                            end
                        end
                    end
                    PH_WAVE: begin
                        tag_next[shift_reg[1:0]*8 +: 8] = tag_reg[shift_reg[1:0]*8 +: 8]
                                                          | in_byte;
                        shift_next = shift_reg + 3'd1;
                        if (shift_reg[1:0] == 2'd3) begin
                            shift_next = '0;
                            if (tag_next != TAG_WAVE) begin
                                halt_now = 1'b1; ecode = ERR_NOT_WAVE;
                            end else phase_next = PH_HEADER;
                        end
                    end
                    PH_FMT: begin
                        unique case (fidx_reg)
                            4'd0, 4'd1: fmt_next[fidx_reg[0]*8 +: 8] = in_byte;
                            4'd2, 4'd3: chans_next[fidx_reg[0]*8 +: 8] = in_byte;
                            4'd4, 4'd5, 4'd6, 4'd7:
                                rate_next[fidx_reg[1:0]*8 +: 8] = in_byte;
                            4'd14, 4'd15: bits_next[fidx_reg[0]*8 +: 8] = in_byte;
                            default: ;
                        endcase
                        fidx_next = fidx_reg + 4'd1;
                        if (fidx_reg == 4'd15) begin
                            shift_next = '0;
                            phase_next = (rem_reg != 0) ? PH_SKIP : PH_HEADER;
                        end
                    end
                    PH_SKIP: begin
                        rem_next = rem_reg - 32'd1;
                        if (rem_next == 0) phase_next = PH_HEADER;
                    end
                    PH_DATA: begin
                        if (!shift_reg[0]) begin
                            low_next = in_byte;
                        end else begin
                            res[0].kind = KIND_SAMPLE;
                            res[0].channel = chan_reg;
                            res[0].frame_index = frame_reg;
                            res[0].sample_value = {in_byte, low_reg};
                            cnt = 2'd1; seen_next = 1'b1;
                            if (chan_reg) frame_next = frame_reg + 30'd1;
                            chan_next = !chan_reg;
                        end
                        shift_next = {2'b00, !shift_reg[0]};
                        rem_next = rem_reg - 32'd1;
                        if (rem_next == 0) begin
                            shift_next = '0; phase_next = PH_HEADER;
                        end
                    end
                    default: ;
                endcase
                if (halt_now) begin
                    res[0].kind = KIND_ERROR; res[0].error_code = ecode;
                    cnt = 2'd1; halt_next = 1'b1;
                end else if (after >= {1'b0, total_len}) begin
                    halt_next = 1'b1;
                    if (phase_next == PH_WAVE) begin
                        res[cnt[0]].kind = KIND_ERROR;
                        res[cnt[0]].error_code = ERR_NOT_WAVE;
                    end else if (seen_next) begin
                        res[cnt[0]].kind = KIND_DONE;
                    end else begin
                        res[cnt[0]].kind = KIND_ERROR;
                        res[cnt[0]].error_code = ERR_NO_DATA;
                    end
                    cnt = cnt + 2'd1;
                end
            end
            pos_next = pos_reg + 32'd1;
        end
        if (cnt == 2'd2) res[1].last = 1'b1;
        else res[0].last = 1'b1;
    end

    assign q_push = acc && (cnt != 2'd0);
    assign q_data = '{two: (cnt == 2'd2), r0: res[0], r1: res[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; pos_reg <= '0; shift_reg <= '0; tag_reg <= '0;
            rem_reg <= '0; fmt_reg <= '0; chans_reg <= '0; rate_reg <= '0;
            bits_reg <= '0; low_reg <= '0; chan_reg <= 1'b0; frame_reg <= '0;
            seen_reg <= 1'b0; halt_reg <= 1'b0; fidx_reg <= '0;
        end else begin
            phase_reg <= phase_next; pos_reg <= pos_next; shift_reg <= shift_next;
            tag_reg <= tag_next; rem_reg <= rem_next; fmt_reg <= fmt_next;
            chans_reg <= chans_next; rate_reg <= rate_next; bits_reg <= bits_next;
            low_reg <= low_next; chan_reg <= chan_next; frame_reg <= frame_next;
            seen_reg <= seen_next; halt_reg <= halt_next; fidx_reg <= fidx_next;
        end
    end
endmodule

// ----- rtl/rwav_queue.sv -----
// Small FIFO of result pairs between the front and back ends.
module rwav_queue import rwav_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  rpair_t push_data,
    output logic   full,
    input  logic   pop,
    output rpair_t pop_data,
    output logic   empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    rpair_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push && !full)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop && !empty)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

// ----- rtl/rwav_back.sv -----
// Back end: splits result pairs into single output words.
module rwav_back import rwav_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  rpair_t  q_data,
    input  logic    q_empty,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);
    logic second_reg;

    assign out_valid = !q_empty;
    assign out_word = second_reg ? q_data.r1 : q_data.r0;
    assign q_pop = out_valid && out_ready && (second_reg || !q_data.two);

    always_ff @(posedge aclk) begin
        if (!aresetn) second_reg <= 1'b0;
        else if (out_valid && out_ready) second_reg <= !second_reg && q_data.two;
    end
endmodule

// ----- rtl/rwav_checker.sv -----
// Port-level checker for the WAV parser, bound to the top level.
`include "assert_macros.svh"
module rwav_checker import rwav_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    `ASSERT_CLK(a_kind_range, aclk, aresetn, !m_tvalid || m_tuser != KIND_SAMPLE + 2'd3, "bad kind")
    `ASSERT_CLK(a_report_last, aclk, aresetn, !m_tvalid || m_tuser == KIND_SAMPLE || m_tlast, "last")
    `ASSERT_CLK(a_sample_clean, aclk, aresetn, !m_tvalid || m_tuser != KIND_SAMPLE || m_tdata[3:0] == '0, "code")
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "drop")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !$past(aresetn) |-> !m_tvalid, "valid after reset")
endmodule

bind riff_wav_pcm_stream_parser_top rwav_checker u_rwav_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

// ----- sim/tb.sv -----
// Testbench for the WAV RIFF stream parser: file stimulus, reference prediction, result check.
`timescale 1ns / 1ps

module tb;
    import rwav_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_FROM = 950;
    localparam int RANDOM_ITEMS = 1020;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  code;
        logic        chan;
        logic [29:0] frame;
        logic [15:0] val;
        logic        last;
    } wav_word_t;

    typedef struct {
        logic [7:0]  b;
        bit          typed;
        logic [1:0]  kind;
        logic [15:0] val;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    riff_wav_pcm_stream_parser_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Parser state as the predictor sees it.
    phase_t      wav_phase = PH_HEADER;
    logic [31:0] file_len = '0;
    logic [31:0] pos = '0;
    logic [31:0] fshift = '0;
    logic [31:0] tag = '0;
    logic [31:0] remain = '0;
    logic [15:0] fmt_code = '0;
    logic [15:0] chans = '0;
    logic [31:0] rate = '0;
    logic [15:0] depth = '0;
    logic [7:0]  low_hold = '0;
    logic        cur_chan = 1'b0;
    logic [29:0] frame_cnt = '0;
    bit          seen_sample = 0;
    bit          halted = 0;

    wav_word_t   expected_words[$];
    logic [7:0]  pend[$];
    int          mismatches = 0;
    int          sent_count = 0;
    int          cycles = 0;
    bit          calm = 0;
    int          stall_left = 0;

    function automatic void push_word(logic [1:0] kind, logic [3:0] code, logic chan,
                                      logic [29:0] frame, logic [15:0] val);
        wav_word_t w;
        w = '{kind: kind, code: code, chan: chan, frame: frame, val: val, last: 1'b0};
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void stop_with(logic [3:0] code);
        push_word(KIND_ERROR, code, 1'b0, '0, '0);
        halted = 1;
    endfunction

    function automatic void store_fmt(int idx, logic [7:0] b);
        case (idx)
            0, 1:       fmt_code[(idx % 2) * 8 +: 8] = b;
            2, 3:       chans[(idx % 2) * 8 +: 8] = b;
            4, 5, 6, 7: rate[(idx - 4) * 8 +: 8] = b;
            14, 15:     depth[(idx % 2) * 8 +: 8] = b;
            default: ;
        endcase
    endfunction

    // Acts on a complete chunk header.
    function automatic void open_chunk();
        logic [31:0] size;
        logic [32:0] left;
        size = remain;
        fshift = 0;
        left = ({1'b0, file_len} > {1'b0, pos} + 33'd1) ?
               {1'b0, file_len} - {1'b0, pos} - 33'd1 : 33'd0;
        if (tag == TAG_RIFF) begin
            tag = '0;
            wav_phase = PH_WAVE;
        end else if (tag == TAG_FMT) begin
            if (size < 32'd16) begin
                stop_with(ERR_FMT_SMALL);
            end else begin
                remain = size - 32'd16;
                wav_phase = PH_FMT;
            end
        end else if (tag == TAG_DATA) begin
            if (chans == 16'd0) stop_with(ERR_NO_FMT);
            else if (fmt_code != 16'd1 || depth != REQ_BITS) stop_with(ERR_FORMAT);
            else if (chans != 16'd2) stop_with(ERR_CHANNELS);
            else if (rate != REQ_RATE) stop_with(ERR_RATE);
            else if ({1'b0, size} > left) stop_with(ERR_BEYOND);
            else if (size[1:0] != 2'b00) stop_with(ERR_NOT_FRAME);
            else begin
                frame_cnt = '0;
                cur_chan = 1'b0;
                seen_sample = 0;
                wav_phase = (size != 0) ? PH_DATA : PH_HEADER;
            end
        end else begin
            wav_phase = (size != 0) ? PH_SKIP : PH_HEADER;
        end
    endfunction

    // Works out the result words that one accepted file byte causes.
    function automatic void parse_byte(logic [7:0] b);
        int n0;
        n0 = expected_words.size();
        if (halted) return;
        if (pos == 0 && file_len < RIFF_HDR_BYTES) begin
            stop_with(ERR_FILE_SMALL);
        end else begin
            case (wav_phase)
                PH_HEADER: begin
                    if (fshift == 0 && {1'b0, pos} + 33'd8 > {1'b0, file_len}) begin
                        wav_phase = PH_TRAIL;
                    end else begin
                        if (fshift < 4) tag[fshift * 8 +: 8] = b;
                        else remain[(fshift - 4) * 8 +: 8] = b;
                        fshift++;
                        if (fshift >= 8) open_chunk();
                    end
                end
                PH_WAVE: begin
                    tag[(fshift % 4) * 8 +: 8] = tag[(fshift % 4) * 8 +: 8] | b;
                    fshift++;
                    if (fshift >= 4) begin
                        fshift = 0;
                        if (tag != TAG_WAVE) stop_with(ERR_NOT_WAVE);
                        else wav_phase = PH_HEADER;
                    end
                end
                PH_FMT: begin
                    store_fmt(fshift % 16, b);
                    fshift++;
                    if (fshift >= 16) begin
                        fshift = 0;
                        wav_phase = (remain != 0) ? PH_SKIP : PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    remain--;
                    if (remain == 0) wav_phase = PH_HEADER;
                end
                PH_DATA: begin
                    if (fshift[0] == 1'b0) begin
                        low_hold = b;
                    end else begin
                        push_word(KIND_SAMPLE, ERR_NOT_WAVE, cur_chan, frame_cnt,
                                  {b, low_hold});
                        seen_sample = 1;
                        if (cur_chan) frame_cnt = frame_cnt + 30'd1;
                        cur_chan = ~cur_chan;
                    end
                    fshift[0] = ~fshift[0];
                    remain--;
                    if (remain == 0) begin
                        fshift = 0;
                        wav_phase = PH_HEADER;
                    end
                end
                default: ;
            endcase
            if (!halted && {1'b0, pos} + 33'd1 >= {1'b0, file_len}) begin
                if (wav_phase == PH_WAVE) begin
                    stop_with(ERR_NOT_WAVE);
                end else if (seen_sample) begin
                    push_word(KIND_DONE, ERR_NOT_WAVE, 1'b0, '0, '0);
                    halted = 1;
                end else begin
                    stop_with(ERR_NO_DATA);
                end
            end
            pos++;
        end
        if (expected_words.size() > n0)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
        mismatches++;
    endtask

    // Result side: check each accepted word and stall at random.
    always @(posedge aclk) begin
        wav_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            end else begin
                want = expected_words.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[3:0] != want.code)
                    report_mismatch("error_code", 32'(m_tdata[3:0]), 32'(want.code));
                if (m_tdata[4] != want.chan)
                    report_mismatch("channel", 32'(m_tdata[4]), 32'(want.chan));
                if (m_tdata[34:5] != want.frame)
                    report_mismatch("frame_index", 32'(m_tdata[34:5]), 32'(want.frame));
                if (m_tdata[50:35] != want.val)
                    report_mismatch("sample_value", 32'(m_tdata[50:35]), 32'(want.val));
                if (m_tlast != want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void add8(logic [7:0] v);
        pend.insert(pend.size(), v);
    endfunction

    function automatic void add16(logic [15:0] v);
        add8(v[7:0]);
        add8(v[15:8]);
    endfunction

    function automatic void add32(logic [31:0] v);
        add16(v[15:0]);
        add16(v[31:16]);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) add8(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_fmt(logic [15:0] code, logic [15:0] nch, logic [31:0] hz,
                                    logic [15:0] bits, int ext);
        add32(TAG_FMT);
        add32(32'd16 + 32'(ext));
        add16(code);
        add16(nch);
        add32(hz);
        add32($urandom);
        add16(16'($urandom));
        add16(bits);
        add_noise(ext);
    endfunction

    task automatic send_word(logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b);
        sent_count++;
    endtask

    // Leaves s_tvalid high after the last byte; the caller drops it when it stops.
    task automatic flush_pend();
        while (pend.size() > 0) send_word(pend.pop_front());
    endtask

    // The block may still be finishing a byte that causes no word.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_words.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_file_len(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        file_len = v;
    endtask

    initial begin
        dir_row_t rows[$];
        int mode;
        logic [31:0] t;

        // RIFF/WAVE header, a plain 48 kHz stereo fmt chunk and a data chunk of
        // two frames holding the sample extremes.
        rows = '{
            '{8'h52, 0, 0, 0}, '{8'h49, 0, 0, 0}, '{8'h46, 0, 0, 0}, '{8'h46, 0, 0, 0},
            '{8'h24, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h57, 0, 0, 0}, '{8'h41, 0, 0, 0}, '{8'h56, 0, 0, 0}, '{8'h45, 0, 0, 0},
            '{8'h66, 0, 0, 0}, '{8'h6d, 0, 0, 0}, '{8'h74, 0, 0, 0}, '{8'h20, 0, 0, 0},
            '{8'h10, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h01, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h02, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h80, 0, 0, 0}, '{8'hbb, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h00, 0, 0, 0}, '{8'hee, 0, 0, 0}, '{8'h02, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h04, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h10, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h64, 0, 0, 0}, '{8'h61, 0, 0, 0}, '{8'h74, 0, 0, 0}, '{8'h61, 0, 0, 0},
            '{8'h08, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
            '{8'h00, 0, 0, 0}, '{8'h80, 1, KIND_SAMPLE, 16'h8000},
            '{8'hff, 0, 0, 0}, '{8'h7f, 1, KIND_SAMPLE, 16'h7fff},
            '{8'h00, 0, 0, 0}, '{8'h00, 1, KIND_SAMPLE, 16'h0000},
            '{8'hff, 0, 0, 0}, '{8'hff, 1, KIND_SAMPLE, 16'hffff}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_file_len(32'hffff_ffff);

        foreach (rows[i]) begin
            send_word(rows[i].b);
            if (rows[i].typed && (expected_words.size() == 0 ||
                expected_words[$].kind != rows[i].kind ||
                expected_words[$].val != rows[i].val))
                report_mismatch("directed sample",
                                expected_words.size() ? 32'(expected_words[$].val) : 32'hx,
                                32'(rows[i].val));
        end

        while (sent_count < RANDOM_ITEMS) begin
            if (sent_count >= CALM_FROM) calm = 1;
            if (sent_count > 500 && file_len == 32'hffff_ffff) begin
                wait_idle();
                write_file_len(32'h8000_0000 | $urandom);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    t = 4 * $urandom_range(0, 12);
                    add32(TAG_DATA);
                    add32(t);
                    add_noise(t);
                end
                5, 6: begin
                    do t = $urandom;
                    while (t == TAG_DATA || t == TAG_FMT || t == TAG_RIFF);
                    add32(t);
                    t = $urandom_range(0, 12);
                    add32(t);
                    add_noise(t);
                end
                7: add_fmt(16'd1, 16'd2, REQ_RATE, REQ_BITS, $urandom_range(0, 6));
                8: begin
                    add32(TAG_RIFF);
                    add32($urandom);
                    add32(TAG_WAVE);
                end
                default: begin
                    add32(TAG_DATA);
                    add32(32'd0);
                end
            endcase
            flush_pend();
        end

        // One closing scenario per run; the parser halts for good after it.
        calm = 1;
        mode = $urandom_range(0, 8);
        case (mode)
            0: begin
                wait_idle();
                write_file_len(pos + 32'd4);
                add_noise(4);
            end
            1: begin
                wait_idle();
                write_file_len(32'd0);
                add_noise(1);
            end
            2: begin
                wait_idle();
                write_file_len(pos + 32'd20);
                add32(TAG_DATA);
                add32(32'd64);
            end
            3: begin
                add32(TAG_DATA);
                add32(32'd6);
            end
            4: begin
                add32(TAG_FMT);
                add32(32'd8);
            end
            5: add_fmt(16'd1, 16'd2, 32'd44100, REQ_BITS, 0);
            6: add_fmt(16'd1, 16'd1, REQ_RATE, REQ_BITS, 0);
            7: add_fmt(16'd3, 16'd2, REQ_RATE, 16'd32, 0);
            default: begin
                add32(TAG_RIFF);
                add32(32'd4);
                add32(32'h58564157);
            end
        endcase
        if (mode >= 5 && mode <= 7) begin
            add32(TAG_DATA);
            add32(32'd4);
        end
        add_noise(6);
        flush_pend();
        s_tvalid <= 1'b0;

        while (expected_words.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
